// ----- hdl/erm_pkg.sv -----
// ----------------------------------------------------------------------------
// erm_pkg
// Shared Q30 fixed-point types, constants and the rounding multiply used by the
// roll, pitch and yaw to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package erm_pkg;

  // Q30 working word. 35 bits cover angles up to about 4 rad before folding.
  typedef logic signed [34:0] q_t;

  localparam int QF        = 30;
  localparam int TERMS     = 9;
  localparam q_t Q_ONE     = 35'sd1073741824;
  localparam q_t PI_Q30    = 35'sd3373259426;

  // Pipeline word carried from cell to cell of the Horner chain.
  typedef struct packed {
    q_t   a;
    q_t   x2;
    q_t   s;
    q_t   c;
    logic flip;
  } sc_t;

  // Product of two Q30 values, rounded to nearest with ties away from zero.
  function automatic q_t qmul(q_t a, q_t b);
    logic        neg;
    logic [34:0] ma;
    logic [34:0] mb;
    logic [69:0] p;
    logic [34:0] mag;
    neg = a[34] ^ b[34];
    ma  = a[34] ? 35'(-a) : 35'(a);
    mb  = b[34] ? 35'(-b) : 35'(b);
    p   = 70'(ma) * 70'(mb) + (70'd1 << (QF - 1));
    mag = p[QF +: 35];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ----- hdl/erm_in_if.sv -----
// ----------------------------------------------------------------------------
// erm_in_if
// Angle channel: one roll, pitch and yaw triple per transaction.
// ----------------------------------------------------------------------------
interface erm_in_if #(
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, output ready);
endinterface

// ----- hdl/erm_out_if.sv -----
// ----------------------------------------------------------------------------
// erm_out_if
// Matrix channel: the nine rotation matrix entries per transaction.
// ----------------------------------------------------------------------------
interface erm_out_if #(
  parameter int OUT_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] m00;
  logic signed [OUT_WIDTH-1:0] m01;
  logic signed [OUT_WIDTH-1:0] m02;
  logic signed [OUT_WIDTH-1:0] m10;
  logic signed [OUT_WIDTH-1:0] m11;
  logic signed [OUT_WIDTH-1:0] m12;
  logic signed [OUT_WIDTH-1:0] m20;
  logic signed [OUT_WIDTH-1:0] m21;
  logic signed [OUT_WIDTH-1:0] m22;

  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output m20, output m21, output m22,
                  input ready);
  modport sink   (input valid, input m00, input m01, input m02, input m10,
                  input m11, input m12, input m20, input m21, input m22,
                  output ready);
endinterface

// ----- hdl/erm_cell.sv -----
// ----------------------------------------------------------------------------
// erm_cell
// One Horner step of the sine and cosine series: multiply by x squared, then
// divide by the term's constant denominator and subtract from one.
// ----------------------------------------------------------------------------
module erm_cell
  import erm_pkg::*;
#(
  parameter int K = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  sc_t  in_d,
  output logic out_valid,
  output sc_t  out_d
);

  localparam int          DS  = (2 * K) * (2 * K + 1);
  localparam int          DC  = (2 * K - 1) * (2 * K);
  localparam int          SHS = 32 + $clog2(DS);
  localparam int          SHC = 32 + $clog2(DC);
  localparam logic [63:0] MS  = ((64'd1 << SHS) + 64'(DS) - 64'd1) / 64'(DS);
  localparam logic [63:0] MC  = ((64'd1 << SHC) + 64'(DC) - 64'd1) / 64'(DC);

  // Truncating division of a product below 2^32 in magnitude by a constant,
  // done as a multiply by the rounded-up reciprocal.
  function automatic q_t div_const(q_t p, logic [32:0] m, int sh);
    logic [31:0] n;
    logic [65:0] prd;
    q_t          q;
    n   = p[34] ? 32'(-p) : 32'(p);
    prd = 66'(n) * 66'(m);
    q   = q_t'(prd >> sh);
    return p[34] ? -q : q;
  endfunction

  sc_t  prod_r;
  logic prod_valid_r;
  sc_t  res_r;
  logic res_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else if (en) begin
      prod_valid_r <= in_valid;
      res_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r.a    <= in_d.a;
      prod_r.x2   <= in_d.x2;
      prod_r.flip <= in_d.flip;
      prod_r.s    <= qmul(in_d.x2, in_d.s);
      prod_r.c    <= qmul(in_d.x2, in_d.c);
      res_r.a     <= prod_r.a;
      res_r.x2    <= prod_r.x2;
      res_r.flip  <= prod_r.flip;
      res_r.s     <= Q_ONE - div_const(prod_r.s, MS[32:0], SHS);
      res_r.c     <= Q_ONE - div_const(prod_r.c, MC[32:0], SHC);
    end
  end

  assign out_valid = res_valid_r;
  assign out_d     = res_r;

endmodule

// ----- hdl/erm_sincos.sv -----
// ----------------------------------------------------------------------------
// erm_sincos
// Sine and cosine of one angle: folding by pi, x squared, a chain of Horner
// cells and the final multiply by the angle.
// ----------------------------------------------------------------------------
module erm_sincos
  import erm_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output logic                          out_valid,
  output q_t                            sn,
  output q_t                            cs
);

  q_t          ang_q;
  q_t          a_nxt;
  logic        flip_nxt;
  logic signed [35:0] a2;

  q_t   a_r;
  logic flip_r;
  logic v0_r;
  sc_t  head_r;
  logic v1_r;
  q_t   sn_r;
  q_t   cs_r;
  logic vo_r;

  sc_t  chain_d [TERMS+1];
  logic chain_v [TERMS+1];

  always_comb begin
    ang_q    = q_t'(angle);
    ang_q    = ang_q <<< (33 - ANGLE_WIDTH);
    a2       = 36'(ang_q) <<< 1;
    a_nxt    = ang_q;
    flip_nxt = 1'b0;
    if (a2 > 36'(PI_Q30)) begin
      a_nxt    = ang_q - PI_Q30;
      flip_nxt = 1'b1;
    end else if (a2 < -36'(PI_Q30)) begin
      a_nxt    = ang_q + PI_Q30;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      vo_r <= chain_v[TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r         <= a_nxt;
      flip_r      <= flip_nxt;
      head_r.a    <= a_r;
      head_r.x2   <= qmul(a_r, a_r);
      head_r.s    <= Q_ONE;
      head_r.c    <= Q_ONE;
      head_r.flip <= flip_r;
      sn_r        <= chain_d[TERMS].flip ? -qmul(chain_d[TERMS].a, chain_d[TERMS].s)
                                         : qmul(chain_d[TERMS].a, chain_d[TERMS].s);
      cs_r        <= chain_d[TERMS].flip ? -chain_d[TERMS].c : chain_d[TERMS].c;
    end
  end

  assign chain_d[0] = head_r;
  assign chain_v[0] = v1_r;

  // Highest-order term first: the cell at position i works on term TERMS - i.
  for (genvar i = 0; i < TERMS; i++) begin : g_cell
    erm_cell #(.K(TERMS - i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (chain_v[i]),
      .in_d     (chain_d[i]),
      .out_valid(chain_v[i+1]),
      .out_d    (chain_d[i+1])
    );
  end

  assign out_valid = vo_r;
  assign sn        = sn_r;
  assign cs        = cs_r;

endmodule

// ----- hdl/euler_zyx_to_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix
// Converts roll, pitch and yaw (Q3.13 radians) into the rotation matrix
// Rz(yaw) * Ry(pitch) * Rx(roll), each entry rounded and saturated in Q2.14.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries                              Handshake
//   in_ch     input      roll_angle, pitch_angle, yaw_angle   valid / ready
//   out_ch    output     m00 .. m22                           valid / ready
//
// One transaction is accepted per clock cycle unless a result is stalled at
// the output. Each transaction passes through the sine and cosine pipelines
// (fold, square, nine two-stage Horner cells, final multiply) and then the
// matrix products, sums and rounding before it reaches the output register.
// The whole pipeline advances on one enable, which is high whenever the output
// register is empty or being drained, so in_ch.ready drops only while a
// finished result is stalled at the output.
// Reset (rst_n low, synchronous) clears the valid bits; data registers are not
// reset.
// ----------------------------------------------------------------------------
module euler_zyx_to_rotation_matrix
  import erm_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16,
  parameter int OUT_WIDTH   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  erm_in_if.sink           in_ch,
  erm_out_if.source        out_ch
);

  localparam int          RSH = 32 - OUT_WIDTH;
  localparam logic [35:0] RND = (36'd1 << RSH) >> 1;
  localparam logic [35:0] LIM = 36'd1 << (OUT_WIDTH - 2);

  // Rounds a Q30 entry to the output format, ties away from zero, and clamps
  // its magnitude to one.
  function automatic logic [OUT_WIDTH-1:0] entry_out(logic signed [35:0] v);
    logic [35:0] m;
    m = v[35] ? 36'(-v) : 36'(v);
    m = (m + RND) >> RSH;
    if (m > LIM) begin
      m = LIM;
    end
    return v[35] ? OUT_WIDTH'(-m) : OUT_WIDTH'(m);
  endfunction

  logic en;
  logic sc_valid;
  q_t   sr, cr, sp, cp, sy, cy;

  // First matrix stage: pairwise products and pass-through terms.
  q_t   cysp_r, sysp_r, p00_r, p10_r, p21_r, p22_r;
  q_t   sycr_r, sysr_r, cycr_r, cysr_r, sr_r, cr_r, nsp_r;
  logic v1_r;

  // Second matrix stage: triple products and pass-through terms.
  q_t   t01_r, t02_r, t11_r, t12_r;
  q_t   u00_r, u10_r, u21_r, u22_r, sycr2_r, sysr2_r, cycr2_r, cysr2_r, nsp2_r;
  logic v2_r;

  logic                 out_valid_r;
  logic [OUT_WIDTH-1:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r;
  logic [OUT_WIDTH-1:0] m20_r, m21_r, m22_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  erm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid && en),
    .angle(in_ch.roll_angle), .out_valid(sc_valid), .sn(sr), .cs(cr)
  );

  // The three angle pipelines run in lockstep; only the roll one's valid
  // line is needed.
  erm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid && en),
    .angle(in_ch.pitch_angle), .out_valid(), .sn(sp), .cs(cp)
  );

  erm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid && en),
    .angle(in_ch.yaw_angle), .out_valid(), .sn(sy), .cs(cy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= sc_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cysp_r  <= qmul(cy, sp);
      sysp_r  <= qmul(sy, sp);
      p00_r   <= qmul(cy, cp);
      p10_r   <= qmul(sy, cp);
      p21_r   <= qmul(cp, sr);
      p22_r   <= qmul(cp, cr);
      sycr_r  <= qmul(sy, cr);
      sysr_r  <= qmul(sy, sr);
      cycr_r  <= qmul(cy, cr);
      cysr_r  <= qmul(cy, sr);
      sr_r    <= sr;
      cr_r    <= cr;
      nsp_r   <= -sp;

      t01_r   <= qmul(cysp_r, sr_r);
      t02_r   <= qmul(cysp_r, cr_r);
      t11_r   <= qmul(sysp_r, sr_r);
      t12_r   <= qmul(sysp_r, cr_r);
      u00_r   <= p00_r;
      u10_r   <= p10_r;
      u21_r   <= p21_r;
      u22_r   <= p22_r;
      sycr2_r <= sycr_r;
      sysr2_r <= sysr_r;
      cycr2_r <= cycr_r;
      cysr2_r <= cysr_r;
      nsp2_r  <= nsp_r;

      m00_r   <= entry_out(36'(u00_r));
      m01_r   <= entry_out(36'(t01_r) - 36'(sycr2_r));
      m02_r   <= entry_out(36'(t02_r) + 36'(sysr2_r));
      m10_r   <= entry_out(36'(u10_r));
      m11_r   <= entry_out(36'(t11_r) + 36'(cycr2_r));
      m12_r   <= entry_out(36'(t12_r) - 36'(cysr2_r));
      m20_r   <= entry_out(36'(nsp2_r));
      m21_r   <= entry_out(36'(u21_r));
      m22_r   <= entry_out(36'(u22_r));
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.m00   = m00_r;
  assign out_ch.m01   = m01_r;
  assign out_ch.m02   = m02_r;
  assign out_ch.m10   = m10_r;
  assign out_ch.m11   = m11_r;
  assign out_ch.m12   = m12_r;
  assign out_ch.m20   = m20_r;
  assign out_ch.m21   = m21_r;
  assign out_ch.m22   = m22_r;

endmodule

// ----- hdl/erm_checker.sv -----
// ----------------------------------------------------------------------------
// erm_checker
// Port-level checks of the rotation matrix block, attached by bind.
// ----------------------------------------------------------------------------
module erm_checker #(
  parameter int OUT_WIDTH = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [OUT_WIDTH-1:0] m00,
  input logic signed [OUT_WIDTH-1:0] m20
);

  localparam int LIM = 1 << (OUT_WIDTH - 2);

  // A result that is offered stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload, checked on m00 and m20.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(m00) && $stable(m20))
    else $error("result changed while stalled");

  // Input side is held back only by a stalled result.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input refused without output backpressure");

  // Saturation keeps entries within plus or minus one, checked on m00 and m20.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> m00 <= LIM && m00 >= -LIM && m20 <= LIM && m20 >= -LIM)
    else $error("matrix entry out of range");

  // Nothing is offered in the first cycle after reset is released.
  a_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind euler_zyx_to_rotation_matrix erm_checker #(.OUT_WIDTH(OUT_WIDTH)) u_erm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .m00      (out_ch.m00),
  .m20      (out_ch.m20)
);

// ----- bench/tb_euler_zyx_to_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// tb_euler_zyx_to_rotation_matrix
// Drives roll, pitch and yaw triples into the rotation matrix pipeline and
// checks every matrix against a fixed-point predictor kept in this bench.
// ----------------------------------------------------------------------------
module tb_euler_zyx_to_rotation_matrix;
  import erm_pkg::q_t;

  typedef logic signed [15:0] ang_t;
  typedef logic signed [15:0] ent_t;

  // One expected matrix, entries row then column.
  typedef struct {
    ent_t m [9];
  } mat_t;

  // Scoreboard: computes the matrix for each accepted triple and holds it until
  // the matching output transaction arrives.
  class rot_scoreboard;
    mat_t pending [$];
    int   errors;

    // Rounding Q30 multiply, ties away from zero.
    static function longint mulq(longint a, longint b);
      logic         neg;
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] p;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      p   = (ma * mb + (128'd1 << 29)) >> 30;
      return neg ? -longint'(p) : longint'(p);
    endfunction

    static function void trig(ang_t ang, output longint sn, output longint cs);
      longint a;
      longint x2;
      longint s;
      longint c;
      longint pi_q;
      logic   flip;
      a    = longint'(ang) * 131072;
      pi_q = 64'd3373259426;
      flip = 1'b0;
      s    = 64'd1 << 30;
      c    = 64'd1 << 30;
      if (2 * a > pi_q) begin
        a    = a - pi_q;
        flip = 1'b1;
      end else if (2 * a < -pi_q) begin
        a    = a + pi_q;
        flip = 1'b1;
      end
      x2 = mulq(a, a);
      // Horner evaluation of the Taylor series; division truncates toward zero.
      for (int k = 9; k >= 1; k--) begin
        s = (64'd1 << 30) - mulq(x2, s) / ((2 * k) * (2 * k + 1));
        c = (64'd1 << 30) - mulq(x2, c) / ((2 * k - 1) * (2 * k));
      end
      s  = mulq(a, s);
      sn = flip ? -s : s;
      cs = flip ? -c : c;
    endfunction

    // Q30 to Q2.14, rounded to nearest and saturated to plus or minus one.
    static function ent_t to_entry(longint v);
      logic   neg;
      longint m;
      neg = v < 0;
      m   = neg ? -v : v;
      m   = (m + (64'd1 << 15)) >>> 16;
      if (m > 16384) m = 16384;
      return neg ? ent_t'(-m) : ent_t'(m);
    endfunction

    function void note_angles(ang_t roll, ang_t pitch, ang_t yaw);
      longint sr, cr, sp, cp, sy, cy, cysp, sysp;
      mat_t   e;
      trig(roll, sr, cr);
      trig(pitch, sp, cp);
      trig(yaw, sy, cy);
      cysp   = mulq(cy, sp);
      sysp   = mulq(sy, sp);
      e.m[0] = to_entry(mulq(cy, cp));
      e.m[1] = to_entry(mulq(cysp, sr) - mulq(sy, cr));
      e.m[2] = to_entry(mulq(cysp, cr) + mulq(sy, sr));
      e.m[3] = to_entry(mulq(sy, cp));
      e.m[4] = to_entry(mulq(sysp, sr) + mulq(cy, cr));
      e.m[5] = to_entry(mulq(sysp, cr) - mulq(cy, sr));
      e.m[6] = to_entry(-sp);
      e.m[7] = to_entry(mulq(cp, sr));
      e.m[8] = to_entry(mulq(cp, cr));
      pending.push_back(e);
    endfunction

    function void check_matrix(mat_t got);
      string names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                           "m20", "m21", "m22"};
      mat_t  e;
      if (pending.size() == 0) begin
        $error("unexpected matrix transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.m[i] !== e.m[i]) begin
          $error("%s: expected %0d, actual %0d", names[i], e.m[i], got.m[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  erm_in_if  #(.ANGLE_WIDTH(16)) in_ch ();
  erm_out_if #(.OUT_WIDTH(16))   out_ch ();

  euler_zyx_to_rotation_matrix #(.ANGLE_WIDTH(16), .OUT_WIDTH(16)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rot_scoreboard sb = new();

  // Idle and stall percentages, changed phase by phase by the stimulus.
  int  src_idle = 0;
  int  snk_stall = 0;
  longint cycles = 0;

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.roll_angle  = '0;
    in_ch.pitch_angle = '0;
    in_ch.yaw_angle   = '0;
    out_ch.ready      = 1'b0;
  end

  // The sink side decides ready at each falling edge; a matrix is taken at the
  // rising edge where valid and ready are both high.
  always @(negedge clk)
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall);

  always @(posedge clk) begin
    mat_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.m = '{out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m10, out_ch.m11,
                out_ch.m12, out_ch.m20, out_ch.m21, out_ch.m22};
      sb.check_matrix(got);
    end
  end

  // Watchdog: far above the slowest legal run under 62 percent stalls.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb_euler_zyx_to_rotation_matrix: FAIL");
      $finish;
    end
  end

  // Presents one triple, with an optional random gap first, and holds it until
  // the transaction completes. Valid stays high when the next item follows.
  task automatic send_angles(ang_t roll, ang_t pitch, ang_t yaw);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.roll_angle  <= roll;
    in_ch.pitch_angle <= pitch;
    in_ch.yaw_angle   <= yaw;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_angles(roll, pitch, yaw);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  // Angles beyond plus or minus pi are legal patterns too, so most random angles
  // stay in range, a share spans the whole 16-bit word and the rest lies near plus or minus pi.
  function automatic ang_t pick_angle();
    int r;
    r = $urandom_range(99);
    if (r < 70) return ang_t'($urandom_range(51472) - 25736);
    if (r < 85) return ang_t'($urandom);
    return ang_t'($urandom_range(1) ? 25736 : -25736) + ang_t'($urandom_range(8) - 4);
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    ang_t edges [12] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                         16'sd6434, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
                         16'sd12869, -16'sd12869};
    int   phase;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: identity, quarter and half turns, pi, and the word extremes
    // that need folding, each angle on its own and some mixed.
    for (int i = 0; i < 12; i++)
      send_angles(edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12]);
    send_angles(16'sd0, 16'sd12868, 16'sd0);
    send_angles(16'sd0, -16'sd12868, 16'sd0);
    send_angles(16'sd25736, 16'sd0, 16'sd0);
    send_angles(16'sd0, 16'sd0, -16'sd25736);
    send_angles(16'sh5555, 16'shAAAA, 16'sh7FFF);
    send_angles(16'shAAAA, 16'sh5555, -16'sd32768);

    // The sender holds off until every matrix so far has come back.
    drop_valid();
    wait_drained();

    for (int n = 0; n < 1250; n++) begin
      phase = n / 250;
      case (phase)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 62; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 62; end
        3: begin src_idle = 33; snk_stall = 33; end
        default: begin src_idle = $urandom_range(1) ? 0 : 50; snk_stall = 20; end
      endcase
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    drop_valid();
    snk_stall = 0;

    // Drain, then wait long enough for any stray result to show.
    wait_drained();
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_euler_zyx_to_rotation_matrix: PASS");
    else
      $display("tb_euler_zyx_to_rotation_matrix: FAIL");
    $finish;
  end
endmodule
